/* design/wsp_pkg.sv */
// Shared constants, types and helpers for the world-to-screen projection block.
`timescale 1ns / 1ps
package wsp_pkg;

	localparam int VIEW_WIDTH  = 1920;
	localparam int VIEW_HEIGHT = 1080;
	localparam int MAX_DIM     = (VIEW_WIDTH > VIEW_HEIGHT) ? VIEW_WIDTH : VIEW_HEIGHT;
	// smallest raw cw with cw * 100000 >= MAX_DIM * 65536
	localparam longint EPS_RAW = (longint'(MAX_DIM) * 65536 + 99999) / 100000;

	localparam int QBITS  = 34;           // quotient bits resolved by the divider
	localparam int NUM_W  = 62;           // |c| * dim * 32768 + cw/2
	localparam int CMP_W  = NUM_W + 5;    // room for den << QBITS
	localparam int SUM_W  = QBITS + 3;    // centre +/- quotient

	localparam logic signed [SUM_W-1:0] CENTRE_X = SUM_W'(longint'(VIEW_WIDTH) * 32768);
	localparam logic signed [SUM_W-1:0] CENTRE_Y = SUM_W'(longint'(VIEW_HEIGHT) * 32768);
	localparam logic signed [31:0] FAR_POS = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic vis;
	} wsp_tag_t;

	function automatic logic signed [31:0] sat_sum(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SUM_W'(longint'(32'sh7FFF_FFFF)))
			r = 32'sh7FFF_FFFF;
		else if (v < -SUM_W'(64'sd2147483648))
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* design/wsp_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module wsp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [wsp_pkg::NUM_W-1:0]  num_x,
	input  logic [wsp_pkg::NUM_W-1:0]  num_y,
	input  logic [31:0]                den,
	input  wsp_pkg::wsp_tag_t          in_tag,
	output logic                       out_vld,
	output logic [wsp_pkg::QBITS:0]    quo_x,
	output logic [wsp_pkg::QBITS:0]    quo_y,
	output wsp_pkg::wsp_tag_t          out_tag
);
	localparam int Q = wsp_pkg::QBITS;
	localparam int C = wsp_pkg::CMP_W;

	logic                      vld_s [0:Q-1];
	logic [C-1:0]              rx_s  [0:Q-1];
	logic [C-1:0]              ry_s  [0:Q-1];
	logic [Q:0]                qx_s  [0:Q-1];
	logic [Q:0]                qy_s  [0:Q-1];
	logic [31:0]               den_s [0:Q-1];
	wsp_pkg::wsp_tag_t         tag_s [0:Q-1];

	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic              v_in;
		logic [C-1:0]      rx_in, ry_in, trial;
		logic [Q:0]        qx_in, qy_in;
		logic [31:0]       d_in;
		wsp_pkg::wsp_tag_t t_in;
		logic              gx, gy;

		if (k == 0) begin : g_first
			always_comb begin
				v_in  = in_vld;
				rx_in = C'(num_x);
				ry_in = C'(num_y);
				d_in  = den;
				t_in  = in_tag;
				// quotient of 2^QBITS or more: flag it, result saturates anyway
				qx_in = '0;
				qy_in = '0;
				qx_in[Q] = C'(num_x) >= (C'(den) << Q);
				qy_in[Q] = C'(num_y) >= (C'(den) << Q);
			end
		end else begin : g_next
			always_comb begin
				v_in  = vld_s[k-1];
				rx_in = rx_s[k-1];
				ry_in = ry_s[k-1];
				d_in  = den_s[k-1];
				t_in  = tag_s[k-1];
				qx_in = qx_s[k-1];
				qy_in = qy_s[k-1];
			end
		end

		assign trial = C'(d_in) << (Q - 1 - k);
		assign gx = rx_in >= trial;
		assign gy = ry_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else
				vld_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			rx_s[k]  <= gx ? rx_in - trial : rx_in;
			ry_s[k]  <= gy ? ry_in - trial : ry_in;
			qx_s[k]  <= qx_in | ((Q+1)'(gx) << (Q - 1 - k));
			qy_s[k]  <= qy_in | ((Q+1)'(gy) << (Q - 1 - k));
			den_s[k] <= d_in;
			tag_s[k] <= t_in;
		end
	end

	assign out_vld = vld_s[Q-1];
	assign quo_x   = qx_s[Q-1];
	assign quo_y   = qy_s[Q-1];
	assign out_tag = tag_s[Q-1];
endmodule

/* design/world_to_screen_projection_top.sv */
// Top level of the world-to-screen projection pipeline with its register port.
`timescale 1ns / 1ps
// Projects world points (Q16.16) through a 4x4 row-major view matrix and maps
// them to viewport pixels. A point is issued by pulsing start; busy is never
// raised, so one point may be issued every clock. Each point gives exactly one
// result, shown for a single cycle with done high; the receiver cannot stall and
// results leave in issue order. The pipeline has five arithmetic stages
// (register, 32x32 multiply, clip sum, viewport scale, numerator build), 34
// one-bit divider stages and the output register. visible is low when clip w
// is below max(width,height)*1e-5; screen_x and screen_y then both read
// 0x7FFFFFFF. Matrix pairs live at byte addresses 8*i on the APB port; write
// them only while no point is in flight.
module world_to_screen_projection_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_y,
	input  logic signed [31:0] world_z,
	output logic               done,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic               visible
);
	localparam int Q = wsp_pkg::QBITS;

	// matrix registers
	logic [63:0] mat_q [0:7];
	logic signed [31:0] m [0:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				mat_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			mat_q[paddr[5:3]] <= pwdata;
		end
	end

	assign prdata = mat_q[paddr[5:3]];
	assign pready = 1'b1;
	assign busy   = 1'b0;

	for (genvar i = 0; i < 8; i++) begin : g_elem
		assign m[2*i]   = mat_q[i][31:0];
		assign m[2*i+1] = mat_q[i][63:32];
	end

	// s1: capture point
	logic vld_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;

	// s2: nine products, for clip columns x, y and w
	logic vld_s2;
	logic signed [63:0] px_s2 [0:2];
	logic signed [63:0] py_s2 [0:2];
	logic signed [63:0] pw_s2 [0:2];

	// s3: clip vector
	logic vld_s3;
	logic signed [31:0] cx_s3, cy_s3, cw_s3;

	// s4: scaled magnitudes
	logic vld_s4, vis_s4;
	logic [45:0] ax_s4, ay_s4;
	logic [31:0] cw_s4;
	logic nx_s4, ny_s4;

	// s5: divider operands
	logic vld_s5;
	logic [wsp_pkg::NUM_W-1:0] nmx_s5, nmy_s5;
	logic [31:0] den_s5;
	wsp_pkg::wsp_tag_t tag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	function automatic logic signed [31:0] clip_sum(
		input logic signed [63:0] p0,
		input logic signed [63:0] p1,
		input logic signed [63:0] p2,
		input logic signed [31:0] t);
		logic signed [65:0] s;
		logic signed [49:0] f;
		s = 66'(p0) + 66'(p1) + 66'(p2) + (66'(t) <<< 16);
		f = 50'(s >>> 16);  // floor to Q16.16
		if (f > 50'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (f < -50'sd2147483648)
			return 32'sh8000_0000;
		return f[31:0];
	endfunction

	logic signed [31:0] cw_c;
	assign cw_c = cw_s3;

	always_ff @(posedge clk) begin
		x_s1 <= world_x;
		y_s1 <= world_y;
		z_s1 <= world_z;

		px_s2[0] <= x_s1 * m[0];
		px_s2[1] <= y_s1 * m[4];
		px_s2[2] <= z_s1 * m[8];
		py_s2[0] <= x_s1 * m[1];
		py_s2[1] <= y_s1 * m[5];
		py_s2[2] <= z_s1 * m[9];
		pw_s2[0] <= x_s1 * m[3];
		pw_s2[1] <= y_s1 * m[7];
		pw_s2[2] <= z_s1 * m[11];

		cx_s3 <= clip_sum(px_s2[0], px_s2[1], px_s2[2], m[12]);
		cy_s3 <= clip_sum(py_s2[0], py_s2[1], py_s2[2], m[13]);
		cw_s3 <= clip_sum(pw_s2[0], pw_s2[1], pw_s2[2], m[15]);

		// magnitudes times viewport size; 2^31 still fits unsigned
		nx_s4  <= cx_s3[31];
		ny_s4  <= cy_s3[31];
		ax_s4  <= 46'(unsigned'(cx_s3[31] ? -cx_s3 : cx_s3)) * 46'(wsp_pkg::VIEW_WIDTH);
		ay_s4  <= 46'(unsigned'(cy_s3[31] ? -cy_s3 : cy_s3)) * 46'(wsp_pkg::VIEW_HEIGHT);
		vis_s4 <= 64'(cw_c) >= 64'(wsp_pkg::EPS_RAW);
		cw_s4  <= cw_c;

		// round to nearest, ties away: (|n| + cw/2) / cw
		nmx_s5 <= (wsp_pkg::NUM_W'(ax_s4) << 15) + wsp_pkg::NUM_W'(cw_s4 >> 1);
		nmy_s5 <= (wsp_pkg::NUM_W'(ay_s4) << 15) + wsp_pkg::NUM_W'(cw_s4 >> 1);
		den_s5 <= cw_s4;
		tag_s5 <= '{neg_x: nx_s4, neg_y: ny_s4, vis: vis_s4};
	end

	logic              dv;
	logic [Q:0]        qx, qy;
	wsp_pkg::wsp_tag_t dtag;

	wsp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s5),
		.num_x   (nmx_s5),
		.num_y   (nmy_s5),
		.den     (den_s5),
		.in_tag  (tag_s5),
		.out_vld (dv),
		.quo_x   (qx),
		.quo_y   (qy),
		.out_tag (dtag)
	);

	logic [Q:0] qxe, qye;
	logic signed [wsp_pkg::SUM_W-1:0] sx_c, sy_c;

	// an overflowed quotient is forced to all ones, which saturates
	assign qxe = qx[Q] ? '1 : qx;
	assign qye = qy[Q] ? '1 : qy;
	assign sx_c = dtag.neg_x ? wsp_pkg::CENTRE_X - wsp_pkg::SUM_W'(qxe)
	                         : wsp_pkg::CENTRE_X + wsp_pkg::SUM_W'(qxe);
	// screen y is flipped
	assign sy_c = dtag.neg_y ? wsp_pkg::CENTRE_Y + wsp_pkg::SUM_W'(qye)
	                         : wsp_pkg::CENTRE_Y - wsp_pkg::SUM_W'(qye);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv;
	end

	always_ff @(posedge clk) begin
		visible  <= dtag.vis;
		screen_x <= dtag.vis ? wsp_pkg::sat_sum(sx_c) : wsp_pkg::FAR_POS;
		screen_y <= dtag.vis ? wsp_pkg::sat_sum(sy_c) : wsp_pkg::FAR_POS;
	end

	// checks
	a_far_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> screen_x == wsp_pkg::FAR_POS && screen_y == wsp_pkg::FAR_POS)
		else $error("invisible item without far position");

	a_vis_track: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> visible == $past(vis_s4, Q + 2))
		else $error("visibility lost its item through the divider");

	a_vld_track: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s4, Q + 2))
		else $error("result without an item behind it");
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the world-to-screen projection block.
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               vis;
	} screen_pt_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               typed;
		screen_pt_t         want;
	} dir_row_t;

	localparam int          NUM_PAIRS = 8;
	localparam int          LATENCY   = 40;
	localparam logic [31:0] ONE       = 32'h0001_0000;
	localparam screen_pt_t  FAR_PT    = '{wsp_pkg::FAR_POS, wsp_pkg::FAR_POS, 1'b0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic               done;
	logic signed [31:0] screen_x, screen_y;
	logic               visible;

	// typed expectation travels with the item it belongs to
	logic               typed_on = 1'b0;
	screen_pt_t         typed_pt = '0;

	logic signed [31:0] view_mat [16];
	screen_pt_t         pending_q [$];
	int                 errors = 0;

	world_to_screen_projection_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(input logic signed [71:0] v);
		if (v > 72'sd2147483647)
			return 64'sd2147483647;
		if (v < -72'sd2147483648)
			return -64'sd2147483648;
		return longint'(v);
	endfunction

	// exact row-vector product for one column, floored to Q16.16
	function automatic longint clip_column(input logic signed [31:0] x, y, z, input int j);
		logic signed [71:0] acc;
		acc = 72'(view_mat[12 + j]) <<< 16;
		acc += 72'(x) * 72'(view_mat[j]);
		acc += 72'(y) * 72'(view_mat[4 + j]);
		acc += 72'(z) * 72'(view_mat[8 + j]);
		return clamp32(acc >>> 16);
	endfunction

	function automatic longint round_div(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic screen_pt_t project_point(input logic signed [31:0] x, y, z);
		longint cx, cy, cw;
		screen_pt_t p;
		cx = clip_column(x, y, z, 0);
		cy = clip_column(x, y, z, 1);
		cw = clip_column(x, y, z, 3);
		if (cw * 100000 < longint'(wsp_pkg::MAX_DIM) * 65536)
			return FAR_PT;
		p.sx  = 32'(clamp32(72'(longint'(wsp_pkg::VIEW_WIDTH) * 32768
			+ round_div(cx * wsp_pkg::VIEW_WIDTH * 32768, cw))));
		p.sy  = 32'(clamp32(72'(longint'(wsp_pkg::VIEW_HEIGHT) * 32768
			- round_div(cy * wsp_pkg::VIEW_HEIGHT * 32768, cw))));
		p.vis = 1'b1;
		return p;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// expectation is formed at the edge the item is taken
	always @(posedge clk) begin
		if (start && !busy)
			pending_q.push_back(typed_on ? typed_pt : project_point(world_x, world_y, world_z));
		if (done) begin
			if (pending_q.size() == 0)
				report("unexpected result", screen_x, 0);
			else begin
				screen_pt_t e;
				e = pending_q.pop_front();
				if (screen_x !== e.sx) report("screen_x", screen_x, e.sx);
				if (screen_y !== e.sy) report("screen_y", screen_y, e.sy);
				if (visible !== e.vis) report("visible", visible, e.vis);
			end
		end
	end

	task automatic write_pair(input int k, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(k * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		view_mat[2 * k]     = v[31:0];
		view_mat[2 * k + 1] = v[63:32];
		@(posedge clk);
	endtask

	task automatic load_matrix(input logic [31:0] m [16]);
		for (int k = 0; k < NUM_PAIRS; k++)
			write_pair(k, {m[2 * k + 1], m[2 * k]});
	endtask

	// block must be drained before the matrix changes
	task automatic drain;
		start <= 1'b0;
		typed_on <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic send_point(input logic [31:0] x, y, z, input logic typed,
			input screen_pt_t want, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		world_x <= x;
		world_y <= y;
		world_z <= z;
		typed_on <= typed;
		typed_pt <= want;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
		end
	endtask

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
			default: return 32'($urandom_range(1 << 14, 300 << 16));
		endcase
	endfunction

	initial begin
		logic [31:0] m [16];
		dir_row_t    rows [$];
		int          idle_set [4];
		int          mode;

		idle_set = '{0, 72, 0, 19};
		foreach (view_mat[i]) view_mat[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the matrix is zero, so clip w is zero and nothing is visible
		rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, FAR_PT});
		rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, FAR_PT});
		rows.push_back('{ONE, ONE, ONE, 1'b1, FAR_PT});
		foreach (rows[i])
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want, 0);
		drain();

		// plain perspective: cx = x, cy = y, cw = z
		foreach (m[i]) m[i] = '0;
		m[0] = ONE;
		m[5] = ONE;
		m[10] = ONE;
		m[11] = ONE;
		load_matrix(m);
		rows.delete();
		rows.push_back('{0, 0, ONE, 1'b1, '{32'(wsp_pkg::VIEW_WIDTH * 32768),
			32'(wsp_pkg::VIEW_HEIGHT * 32768), 1'b1}});
		rows.push_back('{ONE, ONE, ONE, 1'b1, '{32'(wsp_pkg::VIEW_WIDTH * 65536), 0, 1'b1}});
		rows.push_back('{-ONE, -ONE, ONE, 1'b1, '{0, 32'(wsp_pkg::VIEW_HEIGHT * 65536), 1'b1}});
		rows.push_back('{ONE, ONE, 0, 1'b1, FAR_PT});
		rows.push_back('{ONE, ONE, -ONE, 1'b1, FAR_PT});
		// either side of the epsilon threshold
		rows.push_back('{ONE, ONE, 32'(wsp_pkg::EPS_RAW - 1), 1'b1, FAR_PT});
		rows.push_back('{ONE, ONE, 32'(wsp_pkg::EPS_RAW), 1'b0, '0});
		rows.push_back('{-ONE, ONE, 32'(wsp_pkg::EPS_RAW), 1'b0, '0});
		// huge ratios saturate, tiny ones sit at the centre
		rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, ONE, 1'b0, '0});
		rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, ONE, 1'b0, '0});
		rows.push_back('{1, -1, 32'h7FFF_FFFF, 1'b0, '0});
		rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
		// half-unit coordinates whose quotients come out exact in the divide
		rows.push_back('{32'h0000_8000, 32'hFFFF_8000, 32'h0003_0000, 1'b0, '0});
		foreach (rows[i])
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want, 0);
		drain();

		// extreme matrices: every element at the top or bottom of the range
		foreach (m[i]) m[i] = 32'h7FFF_FFFF;
		load_matrix(m);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, 0);
		send_point(0, 0, 0, 1'b0, '0, 0);
		drain();
		foreach (m[i]) m[i] = 32'h8000_0000;
		load_matrix(m);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, 0);
		send_point(32'h7FFF_FFFF, 0, 32'h8000_0000, 1'b0, '0, 0);
		send_point(0, 0, 0, 1'b0, '0, 0);
		drain();

		// random phases: new matrix and idle rate per phase
		for (int ph = 0; ph < 14; ph++) begin
			if (ph % 5 == 4) begin
				// raw 64-bit pairs, every bit free
				for (int k = 0; k < NUM_PAIRS; k++)
					write_pair(k, {$urandom(), $urandom()});
			end else begin
				// camera-like matrix with a positive depth term in the w column
				foreach (m[i]) m[i] = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
				m[3] = 32'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
				m[7] = 32'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
				m[11] = 32'($urandom_range(1 << 15, 2 << 16));
				m[15] = 32'($signed($urandom_range(0, 4 << 16)) - (1 << 16));
				load_matrix(m);
			end
			for (int n = 0; n < 50; n++) begin
				mode = $urandom_range(9) < 2 ? 0 : 1;
				send_point(rand_coord(mode), rand_coord(mode),
					rand_coord(mode == 0 ? 0 : 2), 1'b0, '0, idle_set[ph % 4]);
			end
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("world_to_screen_projection_top test passed");
		else
			$display("world_to_screen_projection_top test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("world_to_screen_projection_top test failed");
		$finish;
	end

endmodule

/* filelist.f */
design/wsp_pkg.sv
design/wsp_div.sv
design/world_to_screen_projection_top.sv
sim/testbench.sv
